// ===== rtl/srect_pkg.sv =====
`timescale 1ns / 1ps

package srect_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int OrW    = ProdW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_start_x;
    logic signed [CoordW-1:0] seg_start_y;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] rect_left;
    logic signed [CoordW-1:0] rect_top;
    logic signed [CoordW-1:0] rect_right;
    logic signed [CoordW-1:0] rect_bottom;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] contact_x;
    logic signed [CoordW-1:0] contact_y;
  } out_t;

  // sign as two flags, zero when neither is set
  typedef struct packed {
    logic p;
    logic n;
  } sgn_t;

  // signs of rectangle coordinate minus segment end point coordinate, and of width r-l and height b-t
  typedef struct packed {
    sgn_t lax;
    sgn_t rax;
    sgn_t lbx;
    sgn_t rbx;
    sgn_t tay;
    sgn_t bay;
    sgn_t tby;
    sgn_t bby;
    sgn_t rl;
    sgn_t bt;
  } dsg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] lax;
    logic signed [DiffW-1:0] rax;
    logic signed [DiffW-1:0] lbx;
    logic signed [DiffW-1:0] rbx;
    logic signed [DiffW-1:0] tay;
    logic signed [DiffW-1:0] bay;
    logic signed [DiffW-1:0] tby;
    logic signed [DiffW-1:0] bby;
    logic signed [DiffW-1:0] rl;
    logic signed [DiffW-1:0] bt;
    logic signed [DiffW-1:0] sum_x;
    logic signed [DiffW-1:0] sum_y;
  } s1_t;

  typedef struct packed {
    logic signed [ProdW-1:0] l_dy;
    logic signed [ProdW-1:0] r_dy;
    logic signed [ProdW-1:0] dx_t;
    logic signed [ProdW-1:0] dx_b;
    dsg_t                    ds;
    logic signed [DiffW-1:0] sum_x;
    logic signed [DiffW-1:0] sum_y;
  } s2_t;

  typedef struct packed {
    sgn_t                    olt;
    sgn_t                    ort;
    sgn_t                    orb;
    sgn_t                    olb;
    dsg_t                    ds;
    logic signed [DiffW-1:0] sum_x;
    logic signed [DiffW-1:0] sum_y;
  } s3_t;

  function automatic sgn_t sgn_of(input logic signed [DiffW-1:0] v);
    sgn_t s;
    s.n = v[DiffW-1];
    s.p = !v[DiffW-1] && (v != '0);
    return s;
  endfunction

  function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
    sgn_t s;
    s.p = (a.p && b.p) || (a.n && b.n);
    s.n = (a.p && b.n) || (a.n && b.p);
    return s;
  endfunction

  function automatic sgn_t sgn_neg(input sgn_t a);
    sgn_t s;
    s.p = a.n;
    s.n = a.p;
    return s;
  endfunction

  function automatic logic sgn_zero(input sgn_t a);
    return !a.p && !a.n;
  endfunction

  // point lies between two bounds, given the signs of bound minus point
  function automatic logic between(input sgn_t a, input sgn_t b);
    return !(a.p && b.p) && !(a.n && b.n);
  endfunction

  function automatic logic edge_meet(input sgn_t s1, input sgn_t s2,
                                     input sgn_t s3, input sgn_t s4,
                                     input logic b1, input logic b2,
                                     input logic b3, input logic b4);
    logic cross12;
    logic cross34;
    cross12 = (s1.p && s2.n) || (s1.n && s2.p);
    cross34 = (s3.p && s4.n) || (s3.n && s4.p);
    return (cross12 && cross34) ||
           (sgn_zero(s1) && b1) || (sgn_zero(s2) && b2) ||
           (sgn_zero(s3) && b3) || (sgn_zero(s4) && b4);
  endfunction

endpackage

// ===== rtl/segment_rectangle_intersect.sv =====
`timescale 1ns / 1ps
// segment versus axis-aligned rectangle hit test
//
// in_valid / in_stall / in_data: each request, one per cycle unless in_stall is high, carries the segment
// end points and the rectangle edges, all signed Q12.4
// out_valid / out_stall / out_data: one result per request, in order, with
// the hit flag and the segment midpoint (zero when there is no hit)
//
// four register stages, from the accepting edge to out_valid:
// differences, products, orientation signs, then edge decisions into the output
// throughput is one request per cycle while out_stall is low; the four 17x17 multipliers in the
// second stage are used once per request
//
// reset clears every stage valid bit, so the pipeline comes up empty
// when out_stall is high the result holds; empty stages ahead of it still
// fill, and in_stall rises only once all four stages hold a request
module segment_rectangle_intersect (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  srect_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output srect_pkg::out_t  out_data
);
  import srect_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  s1_t  d1;
  s2_t  d2;
  s3_t  d3;

  // a stage moves when it is empty or the stage after it moves
  assign en4 = !v4 || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_stall  = !en1;
  assign out_valid = v4;

  srect_diff u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en1),
    .vld_in  (in_valid),
    .data_in (in_data),
    .vld_r   (v1),
    .data_r  (d1)
  );

  srect_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .vld_in  (v1),
    .data_in (d1),
    .vld_r   (v2),
    .data_r  (d2)
  );

  srect_orient u_orient (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .vld_in  (v2),
    .data_in (d2),
    .vld_r   (v3),
    .data_r  (d3)
  );

  srect_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en4),
    .vld_in  (v3),
    .data_in (d3),
    .vld_r   (v4),
    .data_r  (out_data)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.contact_x == '0 && out_data.contact_y == '0))
    else $error("contact point not zero on a miss");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1 && v2 && v3 && v4))
    else $error("input stalled with a bubble in the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1 && !en1) |=> (v1 && $stable(d1)))
    else $error("first stage changed while held");
`endif

endmodule

// ===== rtl/srect_diff.sv =====
`timescale 1ns / 1ps

module srect_diff (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  srect_pkg::in_t   data_in,
  output logic             vld_r,
  output srect_pkg::s1_t   data_r
);
  import srect_pkg::*;

  s1_t data_nxt;
  logic signed [DiffW-1:0] ax, ay, bx, by, l, t, r, b;

  always_comb begin
    ax = DiffW'(data_in.seg_start_x);
    ay = DiffW'(data_in.seg_start_y);
    bx = DiffW'(data_in.seg_end_x);
    by = DiffW'(data_in.seg_end_y);
    l  = DiffW'(data_in.rect_left);
    t  = DiffW'(data_in.rect_top);
    r  = DiffW'(data_in.rect_right);
    b  = DiffW'(data_in.rect_bottom);
    data_nxt.dx    = bx - ax;
    data_nxt.dy    = by - ay;
    data_nxt.lax   = l - ax;
    data_nxt.rax   = r - ax;
    data_nxt.lbx   = l - bx;
    data_nxt.rbx   = r - bx;
    data_nxt.tay   = t - ay;
    data_nxt.bay   = b - ay;
    data_nxt.tby   = t - by;
    data_nxt.bby   = b - by;
    data_nxt.rl    = r - l;
    data_nxt.bt    = b - t;
    data_nxt.sum_x = ax + bx;
    data_nxt.sum_y = ay + by;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/srect_mult.sv =====
`timescale 1ns / 1ps

module srect_mult (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  srect_pkg::s1_t   data_in,
  output logic             vld_r,
  output srect_pkg::s2_t   data_r
);
  import srect_pkg::*;

  s2_t data_nxt;

  // the four corner orientations against the segment share these products
  always_comb begin
    data_nxt.l_dy   = ProdW'(data_in.lax) * ProdW'(data_in.dy);
    data_nxt.r_dy   = ProdW'(data_in.rax) * ProdW'(data_in.dy);
    data_nxt.dx_t   = ProdW'(data_in.dx) * ProdW'(data_in.tay);
    data_nxt.dx_b   = ProdW'(data_in.dx) * ProdW'(data_in.bay);
    data_nxt.ds.lax = sgn_of(data_in.lax);
    data_nxt.ds.rax = sgn_of(data_in.rax);
    data_nxt.ds.lbx = sgn_of(data_in.lbx);
    data_nxt.ds.rbx = sgn_of(data_in.rbx);
    data_nxt.ds.tay = sgn_of(data_in.tay);
    data_nxt.ds.bay = sgn_of(data_in.bay);
    data_nxt.ds.tby = sgn_of(data_in.tby);
    data_nxt.ds.bby = sgn_of(data_in.bby);
    data_nxt.ds.rl  = sgn_of(data_in.rl);
    data_nxt.ds.bt  = sgn_of(data_in.bt);
    data_nxt.sum_x  = data_in.sum_x;
    data_nxt.sum_y  = data_in.sum_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/srect_orient.sv =====
`timescale 1ns / 1ps

module srect_orient (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  srect_pkg::s2_t   data_in,
  output logic             vld_r,
  output srect_pkg::s3_t   data_r
);
  import srect_pkg::*;

  s3_t data_nxt;
  logic signed [OrW-1:0] o_lt, o_rt, o_rb, o_lb;

  function automatic sgn_t or_sgn(input logic signed [OrW-1:0] v);
    sgn_t s;
    s.n = v[OrW-1];
    s.p = !v[OrW-1] && (v != '0);
    return s;
  endfunction

  always_comb begin
    o_lt = OrW'(data_in.l_dy) - OrW'(data_in.dx_t);
    o_rt = OrW'(data_in.r_dy) - OrW'(data_in.dx_t);
    o_rb = OrW'(data_in.r_dy) - OrW'(data_in.dx_b);
    o_lb = OrW'(data_in.l_dy) - OrW'(data_in.dx_b);
    data_nxt.olt   = or_sgn(o_lt);
    data_nxt.ort   = or_sgn(o_rt);
    data_nxt.orb   = or_sgn(o_rb);
    data_nxt.olb   = or_sgn(o_lb);
    data_nxt.ds    = data_in.ds;
    data_nxt.sum_x = data_in.sum_x;
    data_nxt.sum_y = data_in.sum_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/srect_decide.sv =====
`timescale 1ns / 1ps

module srect_decide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  srect_pkg::s3_t   data_in,
  output logic             vld_r,
  output srect_pkg::out_t  data_r
);
  import srect_pkg::*;

  out_t data_nxt;
  dsg_t ds;
  logic box_lt, box_rt, box_rb, box_lb;
  logic hit_top, hit_right, hit_bottom, hit_left, hit;

  always_comb begin
    ds = data_in.ds;
    // corner inside the segment's bounding box
    box_lt = between(ds.lax, ds.lbx) && between(ds.tay, ds.tby);
    box_rt = between(ds.rax, ds.rbx) && between(ds.tay, ds.tby);
    box_rb = between(ds.rax, ds.rbx) && between(ds.bay, ds.bby);
    box_lb = between(ds.lax, ds.lbx) && between(ds.bay, ds.bby);

    // edges are axis aligned, so one cross product term drops out
    hit_top = edge_meet(
      sgn_mul(ds.rl, ds.tay), sgn_mul(ds.rl, ds.tby),
      data_in.olt, data_in.ort,
      between(ds.lax, ds.rax) && sgn_zero(ds.tay),
      between(ds.lbx, ds.rbx) && sgn_zero(ds.tby),
      box_lt, box_rt);
    hit_right = edge_meet(
      sgn_neg(sgn_mul(ds.rax, ds.bt)), sgn_neg(sgn_mul(ds.rbx, ds.bt)),
      data_in.ort, data_in.orb,
      sgn_zero(ds.rax) && between(ds.tay, ds.bay),
      sgn_zero(ds.rbx) && between(ds.tby, ds.bby),
      box_rt, box_rb);
    hit_bottom = edge_meet(
      sgn_neg(sgn_mul(ds.rl, ds.bay)), sgn_neg(sgn_mul(ds.rl, ds.bby)),
      data_in.orb, data_in.olb,
      between(ds.lax, ds.rax) && sgn_zero(ds.bay),
      between(ds.lbx, ds.rbx) && sgn_zero(ds.bby),
      box_rb, box_lb);
    hit_left = edge_meet(
      sgn_mul(ds.lax, ds.bt), sgn_mul(ds.lbx, ds.bt),
      data_in.olb, data_in.olt,
      sgn_zero(ds.lax) && between(ds.tay, ds.bay),
      sgn_zero(ds.lbx) && between(ds.tby, ds.bby),
      box_lb, box_lt);

    hit = hit_top || hit_right || hit_bottom || hit_left;
    data_nxt.hit = hit;
    // midpoint rounds toward minus infinity
    data_nxt.contact_x = hit ? data_in.sum_x[DiffW-1:1] : '0;
    data_nxt.contact_y = hit ? data_in.sum_y[DiffW-1:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import srect_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam int CycleLimit  = 300000;
  localparam int RandomCount = 1250;
  localparam int IdlePct     = 34;
  localparam int HoldCycles  = 150;

  class hit_scoreboard;
    out_t expected_q[$];
    int   failures;

    function int orient_sign(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                             coord_t tx, coord_t ty);
      logic signed [DiffW-1:0] d_tx, d_by, d_bx, d_ty;
      logic signed [ProdW-1:0] p, q;
      logic signed [OrW-1:0]   o;
      d_tx = tx - ax;
      d_by = by - ay;
      d_bx = bx - ax;
      d_ty = ty - ay;
      p = d_tx * d_by;
      q = d_bx * d_ty;
      o = p - q;
      return (o > 0) ? 1 : (o < 0) ? -1 : 0;
    endfunction

    // closed bounding box of a-b holds t
    function bit in_bbox(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                         coord_t tx, coord_t ty);
      coord_t lo_x, hi_x, lo_y, hi_y;
      lo_x = (ax < bx) ? ax : bx;
      hi_x = (ax > bx) ? ax : bx;
      lo_y = (ay < by) ? ay : by;
      hi_y = (ay > by) ? ay : by;
      return lo_x <= tx && tx <= hi_x && lo_y <= ty && ty <= hi_y;
    endfunction

    function bit segments_meet(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                               coord_t x3, coord_t y3, coord_t x4, coord_t y4);
      int s1, s2, s3, s4;
      s1 = orient_sign(x3, y3, x4, y4, x1, y1);
      s2 = orient_sign(x3, y3, x4, y4, x2, y2);
      s3 = orient_sign(x1, y1, x2, y2, x3, y3);
      s4 = orient_sign(x1, y1, x2, y2, x4, y4);
      if (s1 * s2 < 0 && s3 * s4 < 0) return 1'b1;
      return (s1 == 0 && in_bbox(x3, y3, x4, y4, x1, y1)) ||
             (s2 == 0 && in_bbox(x3, y3, x4, y4, x2, y2)) ||
             (s3 == 0 && in_bbox(x1, y1, x2, y2, x3, y3)) ||
             (s4 == 0 && in_bbox(x1, y1, x2, y2, x4, y4));
    endfunction

    function out_t predict_contact(in_t req);
      out_t                    res;
      logic signed [DiffW-1:0] sum_x, sum_y;
      bit                      touched;
      touched =
        segments_meet(req.seg_start_x, req.seg_start_y, req.seg_end_x, req.seg_end_y,
                      req.rect_left, req.rect_top, req.rect_right, req.rect_top) ||
        segments_meet(req.seg_start_x, req.seg_start_y, req.seg_end_x, req.seg_end_y,
                      req.rect_right, req.rect_top, req.rect_right, req.rect_bottom) ||
        segments_meet(req.seg_start_x, req.seg_start_y, req.seg_end_x, req.seg_end_y,
                      req.rect_right, req.rect_bottom, req.rect_left, req.rect_bottom) ||
        segments_meet(req.seg_start_x, req.seg_start_y, req.seg_end_x, req.seg_end_y,
                      req.rect_left, req.rect_bottom, req.rect_left, req.rect_top);
      sum_x = req.seg_start_x + req.seg_end_x;
      sum_y = req.seg_start_y + req.seg_end_y;
      // dropping the low bit of the 17-bit sum floors the midpoint
      res.hit       = touched;
      res.contact_x = touched ? sum_x[DiffW-1:1] : '0;
      res.contact_y = touched ? sum_y[DiffW-1:1] : '0;
      return res;
    endfunction

    function void note_request(in_t req);
      expected_q.push_back(predict_contact(req));
    endfunction

    function void check_result(out_t got);
      out_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("tb: result with nothing pending: hit=%0b x=%0d y=%0d",
                   got.hit, got.contact_x, got.contact_y);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.hit !== exp_res.hit || got.contact_x !== exp_res.contact_x ||
          got.contact_y !== exp_res.contact_y) begin
        failures++;
        if (failures <= 10)
          $display("tb: mismatch exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
                   exp_res.hit, exp_res.contact_x, exp_res.contact_y,
                   got.hit, got.contact_x, got.contact_y);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  hit_scoreboard sb = new();
  int n_sent;
  int cycles;

  segment_rectangle_intersect uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic in_t mk(int ax, int ay, int bx, int by,
                             int l, int t, int r, int b);
    in_t req;
    req.seg_start_x = 16'(ax);
    req.seg_start_y = 16'(ay);
    req.seg_end_x   = 16'(bx);
    req.seg_end_y   = 16'(by);
    req.rect_left   = 16'(l);
    req.rect_top    = 16'(t);
    req.rect_right  = 16'(r);
    req.rect_bottom = 16'(b);
    return req;
  endfunction

  // sender idles at random except for a long burst in the middle of the run
  task automatic send_request(input in_t req);
    while (!(n_sent >= 300 && n_sent < 800) && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    n_sent++;
  endtask

  // receiver: random stalls, a clean stretch, and one long hold-off to fill the pipe
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && n_sent >= 650) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else if (n_sent >= 300 && n_sent < 500) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int   k, l, t, r, b, ax, ay, bx, by, side;
    int   corner_vals[7];
    in_t  req;
    corner_vals = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    n_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_request(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_request(mk(-32768, -32768, 32767, 32767, -100, -100, 100, 100));
    send_request(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    // wholly inside, wholly outside
    send_request(mk(-16, -16, 16, 16, -160, -160, 160, 160));
    send_request(mk(500, 500, 600, 700, -10, -10, 10, 10));
    // proper crossing of the top edge
    send_request(mk(0, -100, 0, 0, -50, -50, 50, 50));
    // collinear with an edge, overlapping and not
    send_request(mk(-100, -50, 100, -50, -50, -50, 50, 50));
    send_request(mk(100, -50, 200, -50, -50, -50, 50, 50));
    // end point on a corner
    send_request(mk(50, 50, 200, 300, -50, -50, 50, 50));
    // swapped corners, zero width, single-point rectangle
    send_request(mk(0, -100, 0, 0, 50, 50, -50, -50));
    send_request(mk(-100, 0, 100, 0, 0, -50, 0, 50));
    send_request(mk(-10, -10, 10, 10, 0, 0, 0, 0));
    // zero-length segment on an edge and inside
    send_request(mk(50, 0, 50, 0, -50, -50, 50, 50));
    send_request(mk(3, 3, 3, 3, -50, -50, 50, 50));
    // odd midpoint sums, negative and positive
    send_request(mk(-3, -1, 0, 0, -2, -2, 2, 2));
    send_request(mk(1, 3, 0, 0, -2, -2, 2, 2));
    // just outside the right edge
    send_request(mk(51, -100, 51, 100, -50, -50, 50, 50));
    send_request(mk(-32768, -32768, -32768, -32767, -32768, -32768, -32767, -32767));
    send_request(mk(32767, 32767, 32767, 32766, 32766, 32766, 32767, 32767));

    repeat (RandomCount) begin
      k = $urandom_range(99);
      if (k < 35 || (k >= 70 && k < 80)) begin
        // ordered rectangle, at least one end strictly inside
        l = pick(-30000, 20000);
        r = l + pick(2, 10000);
        t = pick(-30000, 20000);
        b = t + pick(2, 10000);
        ax = pick(l + 1, r - 1);
        ay = pick(t + 1, b - 1);
        if (k >= 70) begin
          bx = pick(l + 1, r - 1);
          by = pick(t + 1, b - 1);
        end else begin
          bx = $urandom_range(1) ? pick(r + 1, 32767) : pick(-32768, l - 1);
          by = pick(-32768, 32767);
        end
        if ($urandom_range(1)) req = mk(ax, ay, bx, by, l, t, r, b);
        else req = mk(bx, by, ax, ay, l, t, r, b);
      end else if (k < 55) begin
        // tiny grid: collinear cases and touches are common here
        req = mk(pick(-4, 4), pick(-4, 4), pick(-4, 4), pick(-4, 4),
                 pick(-4, 4), pick(-4, 4), pick(-4, 4), pick(-4, 4));
      end else if (k < 70) begin
        req = {$urandom, $urandom, $urandom, $urandom};
      end else if (k < 92) begin
        // one end exactly on an edge line of a random rectangle
        l = pick(-32768, 32767);
        r = pick(-32768, 32767);
        t = pick(-32768, 32767);
        b = pick(-32768, 32767);
        side = $urandom_range(3);
        case (side)
          0: begin ax = pick(-32768, 32767); ay = t; end
          1: begin ax = r; ay = pick(-32768, 32767); end
          2: begin ax = pick(-32768, 32767); ay = b; end
          default: begin ax = l; ay = pick(-32768, 32767); end
        endcase
        if ($urandom_range(1)) begin
          if (side == 0 || side == 2) ax = (l < r) ? pick(l, r) : pick(r, l);
          else ay = (t < b) ? pick(t, b) : pick(b, t);
        end
        bx = pick(-32768, 32767);
        by = pick(-32768, 32767);
        req = mk(ax, ay, bx, by, l, t, r, b);
      end else begin
        req = mk(corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                 corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                 corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                 corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)]);
      end
      send_request(req);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/srect_pkg.sv
rtl/srect_diff.sv
rtl/srect_mult.sv
rtl/srect_orient.sv
rtl/srect_decide.sv
rtl/segment_rectangle_intersect.sv
tb/tb.sv
